@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");
`endif

@@ design/fuan_pkg.sv @@
// Package: shared types and constants of the flow-updating averaging node.
package fuan_pkg;
  localparam int MaxNeighbors = 16;
  localparam int DataWidth    = 32;
  localparam int IdxW         = 4;
  localparam int CntW         = 5;

  localparam logic OP_MSG  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CntW-1:0] REG_NODE_VALUE = 5'd0;
  localparam logic [CntW-1:0] REG_NBR_COUNT  = 5'd1;

  typedef struct packed {
    logic              opcode;
    logic [IdxW-1:0]   neighbor_index;
    logic signed [31:0] msg_flow;
    logic signed [31:0] msg_estimate;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]    out_neighbor;
    logic signed [31:0] out_flow;
    logic signed [31:0] out_estimate;
    logic               last;
  } out_item_t;
endpackage

@@ design/fuan_divider.sv @@
// Module: restoring divider, one quotient bit per cycle, magnitude only.
module fuan_divider import fuan_pkg::*; #(
  parameter int NW = 72,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

@@ design/flow_updating_average_node.sv @@
// Module: top level of one flow-updating averaging node with its sequencer.
// A message transfer stores the sender's flow and estimate, and the input
// stays ready. A round tick runs a sequencer over one shared adder. A pass
// over all MAX_NEIGHBORS slots sums the kept flows. Then comes one result
// transfer per neighbor in use, each waiting for out_ready. A pass forms the
// new flows and sums the estimates. The average comes from a bit-serial
// divide. Last, an update pass runs over all slots. in_ready stays low from
// the tick transfer until the sequencer is idle again, output stalls
// included. The flow and message stores and their flags are clear after
// reset; no clearing pass is needed.
module flow_updating_average_node import fuan_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [CntW-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);
  `include "assert_macros.svh"

  localparam int MAX_NEIGHBORS = MaxNeighbors;
  localparam int DATA_WIDTH    = DataWidth;
  localparam int NI = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int SW = DATA_WIDTH + 8;    // wide accumulator
  localparam int QW = SW;
  localparam int DVW = 8;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001, ST_SUM = 8'b0000_0010, ST_EMIT = 8'b0000_0100,
    ST_FORM = 8'b0000_1000, ST_ES   = 8'b0001_0000, ST_DIV  = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000, ST_WAIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [DATA_WIDTH-1:0] node_value_r;
  logic [CntW-1:0] count_r;
  logic signed [DATA_WIDTH-1:0] flow_r [MAX_NEIGHBORS];
  logic signed [DATA_WIDTH-1:0] rflow_r [MAX_NEIGHBORS];
  logic signed [DATA_WIDTH-1:0] rest_r [MAX_NEIGHBORS];
  logic signed [DATA_WIDTH-1:0] nf_r [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] fpres_r, rvalid_r, np_r;
  logic [NI:0] idx_r;
  logic [NI-1:0] ix;
  logic signed [SW-1:0] acc_r, tot_r;
  logic signed [DATA_WIDTH-1:0] e0_r, avg_r;
  logic [NI:0] n_eff;
  logic div_start, div_done;
  logic [QW-1:0] div_quo, div_num;
  logic div_go_r;

  // Saturate a wide signed value to the data width.
  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SMAX) return SMAX[DATA_WIDTH-1:0];
    if (v < SMIN) return SMIN[DATA_WIDTH-1:0];
    return v[DATA_WIDTH-1:0];
  endfunction

  assign ix = idx_r[NI-1:0];
  assign n_eff = (count_r > CntW'(MAX_NEIGHBORS)) ? (NI+1)'(MAX_NEIGHBORS)
                                                   : (NI+1)'(count_r);

  // Shared adder operand selection.
  logic signed [SW-1:0] add_a, add_b, add_y, cur_nf, cur_ne;
  logic cur_np;
  always_comb begin
    cur_np = rvalid_r[ix] | fpres_r[ix];
    cur_nf = rvalid_r[ix] ? -SW'(rflow_r[ix]) : SW'(flow_r[ix]);
    if (cur_nf > SMAX) cur_nf = SMAX;
    if (!cur_np) cur_nf = '0;
    cur_ne = rvalid_r[ix] ? SW'(rest_r[ix]) : SW'(e0_r);
    add_a = acc_r; add_b = '0;
    case (state_r)
      ST_SUM:  add_b = fpres_r[ix] ? SW'(flow_r[ix]) : '0;
      ST_FORM: add_b = cur_nf;
      ST_ES:   add_b = SW'(sat(SW'(node_value_r) - acc_r));
      ST_UPD:  begin
        add_a = SW'(nf_r[ix]) + SW'(avg_r);
        add_b = -SW'(rest_r[ix]);
        if (!rvalid_r[ix]) add_b = -SW'(e0_r);
      end
      default: add_b = '0;
    endcase
    add_y = add_a + add_b;
  end

  // Divide the magnitude of the registered total; the sign is put back after.
  assign div_num = tot_r[SW-1] ? QW'(-tot_r) : QW'(tot_r);
  logic [DVW-1:0] den;
  assign den = DVW'(n_eff) + DVW'(1);

  // Second accumulator for the estimate total, kept apart from acc.
  logic signed [SW-1:0] est_r;

  fuan_divider #(.NW(QW), .DW(DVW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num + QW'(den >> 1)), .den(den), .done(div_done), .quo(div_quo)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  always_comb begin
    out_data.out_neighbor = IdxW'(idx_r);
    out_data.out_flow     = 32'(fpres_r[ix] ? flow_r[ix] : '0);
    out_data.out_estimate = 32'(e0_r);
    out_data.last         = (idx_r + 1'b1 == n_eff);
  end

  // Start the divide from a flag registered together with the total.
  assign div_start = div_go_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_data.opcode == OP_TICK) state_nxt = ST_SUM;
      ST_SUM:  if (idx_r == (NI+1)'(MAX_NEIGHBORS - 1))
                 state_nxt = (n_eff == '0) ? ST_FORM : ST_EMIT;
      ST_EMIT: if (out_ready && idx_r + 1'b1 == n_eff) state_nxt = ST_FORM;
      ST_FORM: if (n_eff == '0 || idx_r + 1'b1 == n_eff) state_nxt = ST_ES;
      ST_ES:   state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_UPD;
      ST_UPD:  if (idx_r == (NI+1)'(MAX_NEIGHBORS - 1)) state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; node_value_r <= '0; count_r <= CntW'(1);
      fpres_r <= '0; rvalid_r <= '0; np_r <= '0; idx_r <= '0;
      div_go_r <= 1'b0;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        flow_r[i] <= '0; rflow_r[i] <= '0; rest_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      div_go_r <= (state_r == ST_ES);
      if (cfg_we && cfg_index == REG_NODE_VALUE)
        node_value_r <= DATA_WIDTH'(signed'(cfg_wdata));
      if (cfg_we && cfg_index == REG_NBR_COUNT) count_r <= cfg_wdata[CntW-1:0];
      case (state_r)
        ST_IDLE: begin
          idx_r <= '0; acc_r <= '0;
          // Store a message and mark it received.
          if (in_valid && in_data.opcode == OP_MSG
              && 32'(in_data.neighbor_index) < 32'(MAX_NEIGHBORS)) begin
            rflow_r[NI'(in_data.neighbor_index)] <= DATA_WIDTH'(in_data.msg_flow);
            rest_r[NI'(in_data.neighbor_index)]  <= DATA_WIDTH'(in_data.msg_estimate);
            rvalid_r[NI'(in_data.neighbor_index)] <= 1'b1;
          end
        end
        ST_SUM: begin
          acc_r <= add_y;
          idx_r <= idx_r + 1'b1;
          if (idx_r == (NI+1)'(MAX_NEIGHBORS - 1)) begin
            e0_r <= sat(SW'(node_value_r) - add_y);
            idx_r <= '0;
          end
        end
        ST_EMIT: if (out_ready) begin
          idx_r <= (idx_r + 1'b1 == n_eff) ? '0 : idx_r + 1'b1;
          if (idx_r + 1'b1 == n_eff) begin acc_r <= '0; est_r <= '0; end
        end
        ST_FORM: begin
          if (state_r == ST_FORM && n_eff == '0) begin
            acc_r <= '0; est_r <= '0;
          end else begin
            acc_r <= add_y;
            nf_r[ix] <= cur_nf[DATA_WIDTH-1:0];
            np_r[ix] <= cur_np;
            est_r <= est_r + cur_ne;
            idx_r <= (idx_r + 1'b1 == n_eff) ? '0 : idx_r + 1'b1;
          end
        end
        ST_ES: begin
          tot_r <= est_r + SW'(sat(SW'(node_value_r) - acc_r));
        end
        ST_DIV: if (div_done) begin
          avg_r <= sat(tot_r[SW-1] ? -SW'(div_quo) : SW'(div_quo));
          idx_r <= '0;
        end
        ST_UPD: begin
          if (idx_r < n_eff && np_r[ix]) begin
            flow_r[ix] <= sat(add_y); fpres_r[ix] <= 1'b1;
          end else begin
            flow_r[ix] <= '0; fpres_r[ix] <= 1'b0;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == (NI+1)'(MAX_NEIGHBORS - 1)) begin
            idx_r <= '0; rvalid_r <= '0; np_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `CHK_IMPLY(a_out_only_emit, clk, rst_n, out_valid, state_r == ST_EMIT)
  `CHK_NEXT(a_tick_starts, clk, rst_n, in_valid && in_ready && in_data.opcode == OP_TICK,
            state_r == ST_SUM)
  `CHK_IMPLY(a_idx_range, clk, rst_n, state_r == ST_EMIT, idx_r < n_eff)
endmodule

@@ sim/tb_top.sv @@
// Testbench for the flow-updating averaging node: directed and random stimulus against a built-in predictor.
module tb_top;
  import fuan_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [CntW-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  flow_updating_average_node dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the node's state and registers.
  logic signed [31:0] node_val;
  logic [CntW-1:0]    nbr_cnt;
  logic signed [31:0] kept_flow [MaxNeighbors];
  logic               kept_ok   [MaxNeighbors];
  logic               rx_ok     [MaxNeighbors];
  logic signed [31:0] rx_flow   [MaxNeighbors];
  logic signed [31:0] rx_est    [MaxNeighbors];

  in_item_t  pending_items[$];
  out_item_t expected_msgs[$];
  int        n_errors;
  int        n_ticks;
  int        n_msgs_seen;
  bit        quiet_out;
  bit        quiet_in;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Apply one accepted transfer to the mirror; queue the messages a tick emits.
  task automatic predict_node(input in_item_t it);
    logic signed [63:0] sum, total, mag, q;
    logic signed [31:0] est0, est_s, avg;
    logic signed [31:0] nf [MaxNeighbors];
    logic               np [MaxNeighbors];
    logic signed [31:0] ne [MaxNeighbors];
    out_item_t          o;
    int                 n;
    if (it.opcode == OP_MSG) begin
      rx_flow[it.neighbor_index] = it.msg_flow;
      rx_est[it.neighbor_index]  = it.msg_estimate;
      rx_ok[it.neighbor_index]   = 1'b1;
      return;
    end
    n_ticks++;
    n = (nbr_cnt > MaxNeighbors) ? MaxNeighbors : int'(nbr_cnt);
    sum = 0;
    for (int i = 0; i < MaxNeighbors; i++)
      if (kept_ok[i]) sum += 64'(kept_flow[i]);
    est0 = clamp32(64'(node_val) - sum);
    for (int i = 0; i < n; i++) begin
      o.out_neighbor = i[IdxW-1:0];
      o.out_flow     = kept_ok[i] ? kept_flow[i] : 32'sd0;
      o.out_estimate = est0;
      o.last         = (i == n - 1);
      expected_msgs.push_back(o);
    end
    sum = 0;
    for (int i = 0; i < n; i++) begin
      if (rx_ok[i]) begin
        nf[i] = clamp32(-64'(rx_flow[i]));
        np[i] = 1'b1;
      end else if (kept_ok[i]) begin
        nf[i] = kept_flow[i];
        np[i] = 1'b1;
      end else begin
        nf[i] = 0;
        np[i] = 1'b0;
      end
      if (np[i]) sum += 64'(nf[i]);
      ne[i] = rx_ok[i] ? rx_est[i] : est0;
    end
    est_s = clamp32(64'(node_val) - sum);
    total = 64'(est_s);
    for (int i = 0; i < n; i++) total += 64'(ne[i]);
    // Round to nearest, ties away from zero.
    mag = (total < 0) ? -total : total;
    q   = (mag + (n + 1) / 2) / (n + 1);
    avg = (total < 0) ? -q[31:0] : q[31:0];
    for (int i = 0; i < MaxNeighbors; i++) begin
      if (i < n && np[i]) begin
        kept_flow[i] = clamp32(64'(nf[i]) + 64'(avg) - 64'(ne[i]));
        kept_ok[i]   = 1'b1;
      end else begin
        kept_flow[i] = 0;
        kept_ok[i]   = 1'b0;
      end
      rx_ok[i] = 1'b0;
    end
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
      3: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_msg(input int idx, input logic signed [31:0] f,
                                        input logic signed [31:0] e);
    in_item_t it;
    it.opcode = OP_MSG;
    it.neighbor_index = idx[IdxW-1:0];
    it.msg_flow = f;
    it.msg_estimate = e;
    return it;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    it.opcode = OP_TICK;
    it.neighbor_index = IdxW'($urandom);
    it.msg_flow = 32'($urandom);
    it.msg_estimate = 32'($urandom);
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: present the head of the queue, advance on transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_node(in_data);
      void'(pending_items.pop_front());
    end
  end

  logic in_done_edge;
  always @(posedge clk) in_done_edge <= rst_n && in_valid && in_ready;

  // Decide the next valid at the falling edge; hold until transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_done_edge) begin
        if (pending_items.size() > 0 && (quiet_in || $urandom_range(0, 99) >= 31)) begin
          in_valid <= 1'b1;
          in_data  <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet_out || ($urandom_range(0, 99) >= 31);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      n_msgs_seen++;
      if (expected_msgs.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        n_errors++;
      end else begin
        e = expected_msgs.pop_front();
        if (out_data.out_neighbor !== e.out_neighbor) begin
          $error("out_neighbor: expected %0d, got %0d", e.out_neighbor, out_data.out_neighbor);
          n_errors++;
        end
        if (out_data.out_flow !== e.out_flow) begin
          $error("out_flow: expected %0d, got %0d", e.out_flow, out_data.out_flow);
          n_errors++;
        end
        if (out_data.out_estimate !== e.out_estimate) begin
          $error("out_estimate: expected %0d, got %0d", e.out_estimate,
                 out_data.out_estimate);
          n_errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_data.last);
          n_errors++;
        end
      end
    end
  end

  // Drain: wait until both queues are empty and no input is valid, then wait out the drain delay.
  task automatic settle();
    while (pending_items.size() > 0 || in_valid || expected_msgs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CntW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NODE_VALUE) node_val = val;
    else nbr_cnt = val[CntW-1:0];
  endtask

  // One random round: some messages, mostly to neighbors in use, then a tick.
  task automatic add_round(input int n_used);
    int k;
    k = $urandom_range(0, n_used);
    for (int j = 0; j < k; j++)
      pending_items.push_back(make_msg(
          ($urandom_range(0, 9) < 8) ? $urandom_range(0, (n_used > 0 ? n_used : 1) - 1)
                                     : $urandom_range(0, 15),
          rand_val(), rand_val()));
    pending_items.push_back(make_tick());
  endtask

  initial begin
    int counts [6] = '{1, 16, 3, 0, 20, 7};
    n_errors = 0; n_ticks = 0; n_msgs_seen = 0;
    quiet_in = 0; quiet_out = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    node_val = 0; nbr_cnt = 1;
    for (int i = 0; i < MaxNeighbors; i++) begin
      kept_flow[i] = 0; kept_ok[i] = 0; rx_ok[i] = 0; rx_flow[i] = 0; rx_est[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, negation of the minimum, stale and unused indices.
    write_reg(REG_NODE_VALUE, 32'h7fffffff);
    write_reg(REG_NBR_COUNT, 4);
    pending_items.push_back(make_tick());
    pending_items.push_back(make_msg(0, 32'sh80000000, 32'sh7fffffff));
    pending_items.push_back(make_msg(1, 32'sh7fffffff, 32'sh80000000));
    pending_items.push_back(make_msg(2, 32'sh00010000, -32'sh00010000));
    pending_items.push_back(make_msg(15, 32'sh12345678, 32'sh0));
    pending_items.push_back(make_msg(2, -32'sh00020000, 32'sh00030000));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_tick());
    settle();
    write_reg(REG_NBR_COUNT, 1);
    write_reg(REG_NODE_VALUE, 32'h80000000);
    pending_items.push_back(make_msg(0, 32'sh0, 32'sh0));
    pending_items.push_back(make_tick());
    settle();
    write_reg(REG_NBR_COUNT, 0);
    pending_items.push_back(make_tick());
    settle();
    write_reg(REG_NBR_COUNT, 31);
    for (int i = 0; i < 16; i++)
      pending_items.push_back(make_msg(i, rand_val(), rand_val()));
    pending_items.push_back(make_tick());
    settle();

    // Random phases over several settings; one phase runs with no idling.
    foreach (counts[p]) begin
      write_reg(REG_NODE_VALUE, rand_val());
      write_reg(REG_NBR_COUNT, counts[p]);
      quiet_in = (p == 2); quiet_out = (p == 2);
      for (int r = 0; r < 3; r++)
        add_round(counts[p] > 16 ? 16 : counts[p]);
      settle();
    end
    quiet_in = 0; quiet_out = 0;

    $display("covered %0d ticks and %0d result transfers across six register settings",
             n_ticks, n_msgs_seen);
    if (n_errors == 0)
      $display("flow_updating_average_node: match");
    else
      $display("flow_updating_average_node: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("flow_updating_average_node: mismatch");
    $finish;
  end
endmodule
